// ----- hw/rtl/lcadc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcadc_pkg
// Shared types and constants for the load-cell converter reader.
// ----------------------------------------------------------------------------
package lcadc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SUM_W       = 28;
  localparam int HALF_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = 24'h800000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;

  // per-tick record handed from the serial front to the averaging back
  typedef struct packed {
    logic                   clock_pin;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample_value;
  } tick_t;

endpackage

// ----- hw/rtl/lcadc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcadc_front
// Serial clock generator and bit shifter; one record per accepted tick.
// ----------------------------------------------------------------------------
module lcadc_front import lcadc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              data_pin,
  input  logic [HALF_W-1:0] half_period_ticks,
  output tick_t             rec
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic [1:0]             phase, phase_next;
  logic [4:0]             pulse_count, pulse_count_next;
  logic [HALF_W-1:0]      tick_count, tick_count_next;
  logic [SAMPLE_BITS-1:0] shift_word, shift_word_next;
  logic [SAMPLE_BITS-1:0] last_sample, last_sample_next;
  logic [HALF_W-1:0]      half;
  logic [HALF_W-1:0]      tick_inc;
  logic [4:0]             pulse_inc;

  always_comb begin
    half             = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
    tick_inc         = tick_count + HALF_W'(1);
    pulse_inc        = pulse_count + 5'd1;
    phase_next       = phase;
    pulse_count_next = pulse_count;
    tick_count_next  = tick_count;
    shift_word_next  = shift_word;
    last_sample_next = last_sample;
    rec.clock_pin    = 1'b0;
    rec.sample_valid = 1'b0;
    unique case (phase)
      PH_HIGH: begin
        rec.clock_pin   = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= half) begin
          tick_count_next = '0;
          phase_next      = PH_LOW;
        end
      end
      PH_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= half) begin
          tick_count_next = '0;
          if (pulse_count < 5'(SAMPLE_BITS)) begin
            shift_word_next  = {shift_word[SAMPLE_BITS-2:0], data_pin};
            pulse_count_next = pulse_inc;
            if (pulse_inc == 5'(SAMPLE_BITS)) begin
              last_sample_next = shift_word_next ^ SIGN_FLIP;
              rec.sample_valid = 1'b1;
            end
            phase_next = PH_HIGH;
          end else begin
            // gain pulse done
            pulse_count_next = '0;
            phase_next       = PH_WAIT;
          end
        end
      end
      default: begin
        phase_next = PH_WAIT;
        if (!data_pin) begin
          phase_next       = PH_HIGH;
          tick_count_next  = '0;
          pulse_count_next = '0;
          shift_word_next  = '0;
        end
      end
    endcase
    rec.sample_value = last_sample_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      pulse_count <= '0;
      tick_count  <= '0;
      shift_word  <= '0;
      last_sample <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      pulse_count <= pulse_count_next;
      tick_count  <= tick_count_next;
      shift_word  <= shift_word_next;
      last_sample <= last_sample_next;
    end
  end

endmodule

// ----- hw/rtl/lcadc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcadc_queue
// Four-entry FIFO of tick records between front and back.
// ----------------------------------------------------------------------------
module lcadc_queue import lcadc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output tick_t head
);

  tick_t      entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full      = (count == 3'd4);
  assign not_empty = (count != 3'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- hw/rtl/lcadc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcadc_back
// Batch accumulate, reciprocal divide and baseline compare, three stages.
// ----------------------------------------------------------------------------
module lcadc_back import lcadc_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_not_empty,
  input  tick_t                  q_head,
  output logic                   q_pop,
  input  logic [CFG_DATA_W-1:0]  detect_threshold,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   clock_pin,
  output logic                   sample_valid,
  output logic [SAMPLE_BITS-1:0] sample_value,
  output logic                   average_valid,
  output logic [SAMPLE_BITS-1:0] average_value,
  output logic                   baseline_ready,
  output logic                   object_present
);

  localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int SHIFT  = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RW     = SUM_W + 2;
  localparam int PW     = SUM_W + RW;
  localparam int TW     = CFG_DATA_W + CNT_W;
  localparam logic [63:0] RECIP64 =
      ((64'd1 << SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
  localparam logic [RW-1:0]    RECIP  = RECIP64[RW-1:0];
  localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(SAMPLES_PER_AVERAGE);

  logic advance;

  // stage A
  logic [CNT_W-1:0] batch_count;
  logic [SUM_W-1:0] batch_sum;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_add;
  logic             a_valid;
  tick_t            a_rec;
  logic             a_done;
  logic [SUM_W-1:0] a_sum;

  // stage B
  logic             b_valid;
  tick_t            b_rec;
  logic             b_done;
  logic [SUM_W-1:0] b_sum;
  logic [PW-1:0]    b_prod;
  logic [SUM_W-1:0] b_diff;
  logic [TW-1:0]    b_thr;

  // stage C / output state
  logic [SUM_W-1:0] base_sum;

  assign advance = !result_valid || !result_stall;
  assign q_pop   = advance && q_not_empty;
  assign sum_add = batch_sum + SUM_W'(q_head.sample_value);
  assign cnt_add = batch_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count <= '0;
      batch_sum   <= '0;
      a_valid     <= 1'b0;
    end else if (advance) begin
      a_valid <= q_pop;
      if (q_pop && q_head.sample_valid) begin
        if (cnt_add == N_CNT) begin
          batch_count <= '0;
          batch_sum   <= '0;
        end else begin
          batch_count <= cnt_add;
          batch_sum   <= sum_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_rec  <= q_head;
      a_done <= q_pop && q_head.sample_valid && (cnt_add == N_CNT);
      a_sum  <= sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_rec  <= a_rec;
      b_done <= a_valid && a_done;
      b_sum  <= a_sum;
      b_prod <= PW'(a_sum) * PW'(RECIP);
      b_diff <= (a_sum >= base_sum) ? (a_sum - base_sum) : (base_sum - a_sum);
      b_thr  <= TW'(detect_threshold) * TW'(N_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      clock_pin      <= 1'b0;
      sample_valid   <= 1'b0;
      sample_value   <= '0;
      average_valid  <= 1'b0;
      average_value  <= '0;
      baseline_ready <= 1'b0;
      object_present <= 1'b0;
      base_sum       <= '0;
    end else if (advance) begin
      result_valid <= b_valid;
      if (b_valid) begin
        clock_pin     <= b_rec.clock_pin;
        sample_valid  <= b_rec.sample_valid;
        sample_value  <= b_rec.sample_value;
        average_valid <= b_done;
        if (b_done) begin
          average_value <= b_prod[SHIFT +: SAMPLE_BITS];
          if (!baseline_ready) begin
            base_sum       <= b_sum;
            baseline_ready <= 1'b1;
          end else begin
            object_present <= (32'(b_diff) > 32'(b_thr));
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/load_cell_adc_reader_with_presence.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_presence
// Bit-banged 24-bit load-cell converter reader with batch averaging and
// baseline-relative object presence detection.
// ----------------------------------------------------------------------------
// Path: a tick request's result is registered in the queue write, the accumulate
//   stage, the divide stage and the output register before it leaves.
// Throughput: one tick request per cycle while the queue has room (tick_stall low),
//   set by the front state update and the fully pipelined back stages.
// Reset (rst, synchronous): serial state machine to wait-for-data, counters,
//   sums, baseline and flags cleared, queue emptied; registers to defaults
//   (half period 2, threshold 50000).
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_presence import lcadc_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  // tick requests
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  logic                   data_pin,
  // results
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   clock_pin,
  output logic                   sample_valid,
  output logic [SAMPLE_BITS-1:0] sample_value,
  output logic                   average_valid,
  output logic [SAMPLE_BITS-1:0] average_value,
  output logic                   baseline_ready,
  output logic                   object_present,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [HALF_W-1:0]     half_period_ticks;
  logic [CFG_DATA_W-1:0] detect_threshold;
  logic                  tick_accept;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  tick_t                 front_rec;
  tick_t                 q_head;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_W'(2);
      detect_threshold  <= CFG_DATA_W'(50000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_data[HALF_W-1:0];
        REG_THRESHOLD:   detect_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front only advances when its record has a queue slot, so the
  // serial protocol stalls cleanly with the input.
  assign tick_stall  = q_full;
  assign tick_accept = tick_valid && !tick_stall;

  // Front: drives the serial clock and shifts in data bits, one record
  // per tick carrying clock level, sample strobe and latest sample.
  lcadc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (tick_accept),
    .data_pin          (data_pin),
    .half_period_ticks (half_period_ticks),
    .rec               (front_rec)
  );

  // Short queue decouples the front from output back-pressure.
  lcadc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tick_accept),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: batch sum, divide by reciprocal multiply, compare with the
  // baseline sum against threshold times batch size. Its last stage is
  // the output register.
  lcadc_back #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .detect_threshold (detect_threshold),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .clock_pin        (clock_pin),
    .sample_valid     (sample_valid),
    .sample_value     (sample_value),
    .average_valid    (average_valid),
    .average_value    (average_value),
    .baseline_ready   (baseline_ready),
    .object_present   (object_present)
  );

endmodule
